[rtl/ecc_pkg.sv]
// Shared types, constants and calendar helpers for the epoch calendar converter.
package ecc_pkg;

    localparam int unsigned DivBits   = 32;
    localparam int unsigned DvsW      = 17;
    localparam int unsigned MagicW    = 26;
    localparam int unsigned PreW      = 3;
    localparam int unsigned PostW     = 6;
    localparam int unsigned ProdW     = DivBits + MagicW;

    localparam logic [DvsW-1:0] SecsPerDay  = 17'd86400;
    localparam logic [DvsW-1:0] SecsPerHour = 17'd3600;
    localparam logic [DvsW-1:0] SecsPerMin  = 17'd60;
    localparam logic [DvsW-1:0] DaysPerWeek = 17'd7;

    // Reciprocals and shifts for the constant divisions. 86400 is 2^7 * 675, so a day
    // division first drops seven bits and then divides a 25-bit value by 675.
    localparam logic [MagicW-1:0] MagicDay  = 26'd50903317;
    localparam logic [MagicW-1:0] MagicHour = 26'd149131;
    localparam logic [MagicW-1:0] MagicMin  = 26'd4370;
    localparam logic [MagicW-1:0] MagicWeek = 26'd74899;

    localparam logic [PreW-1:0]   PreDay    = 3'd7;
    localparam logic [PreW-1:0]   PreNone   = 3'd0;

    localparam logic [PostW-1:0]  PostDay   = 6'd35;
    localparam logic [PostW-1:0]  PostHour  = 6'd29;
    localparam logic [PostW-1:0]  PostMin   = 6'd18;
    localparam logic [PostW-1:0]  PostWeek  = 6'd19;

    localparam logic [7:0] FirstYear   = 8'd70;
    localparam logic [3:0] LastMonth0  = 4'd11;

    localparam logic       ActToCal    = 1'b0;
    localparam logic       ActToSecs   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_DAY,
        ST_DIV_HOUR,
        ST_DIV_MIN,
        ST_DIV_WDAY,
        ST_YEAR,
        ST_MONTH,
        ST_C_YEAR,
        ST_C_MONTH,
        ST_MUL_DAY,
        ST_MUL_HOUR,
        ST_MUL_MIN,
        ST_ADD_SEC,
        ST_DONE
    } state_t;

    typedef logic [4:0] mlen_t;

    localparam mlen_t MonthLen [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Every year whose offset from 1900 is a multiple of four is a leap year.
    function automatic logic [8:0] year_days(input logic [7:0] y);
        year_days = (y[1:0] == 2'b00) ? 9'd366 : 9'd365;
    endfunction

    function automatic mlen_t month_days(input logic [3:0] m0, input logic [7:0] y);
        mlen_t d;
        d = (m0 <= LastMonth0) ? MonthLen[m0] : MonthLen[0];
        if (m0 == 4'd1 && y[1:0] == 2'b00)
        begin
            d = 5'd29;
        end
        month_days = d;
    endfunction

endpackage

[rtl/epoch_calendar_converter_top.sv]
// Top level of the epoch calendar converter: sequencer, shared multiplier and adder.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  request   | start, accepted if !busy   | action, in_seconds, in_second .. in_year
//  result    | done, one-cycle strobe     | out_seconds, out_second .. out_weekday
//
// Seconds to calendar: four divisions in turn, then one step per year stepped after 1970
// (up to 136) and per month (up to 11) before done rises. Calendar to seconds: the same year
// and month walk, then four multiply and add steps before done rises.
// busy stays high from acceptance through the done cycle; reset is asynchronous and returns
// the sequencer to idle. The receiver cannot stall, so done is high for exactly one cycle.
module epoch_calendar_converter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [31:0] in_seconds,
    input  logic [5:0]  in_second,
    input  logic [5:0]  in_minute,
    input  logic [4:0]  in_hour,
    input  logic [4:0]  in_day,
    input  logic [3:0]  in_month,
    input  logic [6:0]  in_year,
    output logic        done,
    output logic [31:0] out_seconds,
    output logic [5:0]  out_second,
    output logic [5:0]  out_minute,
    output logic [4:0]  out_hour,
    output logic [4:0]  out_day,
    output logic [3:0]  out_month,
    output logic [7:0]  out_year,
    output logic [2:0]  out_weekday
);

    ecc_pkg::state_t state_reg, state_next;

    logic        act_reg, act_next;
    logic [15:0] day_reg, day_next;
    logic [7:0]  year_reg, year_next;
    logic [7:0]  ytgt_reg, ytgt_next;
    logic [3:0]  month_reg, month_next;
    logic [3:0]  cmon_reg, cmon_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hour_reg, hour_next;
    logic [4:0]  dom_reg, dom_next;
    logic [2:0]  wday_reg, wday_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] prod_reg, prod_next;

    logic                      div_start;
    logic [ecc_pkg::DivBits-1:0] div_dividend;
    logic [ecc_pkg::DvsW-1:0]    div_divisor;
    logic [ecc_pkg::DivBits-1:0] div_quo;
    logic [ecc_pkg::DvsW-1:0]    div_rem;
    logic                      div_done;

    logic [31:0] mul_a;
    logic [16:0] mul_b;
    logic [48:0] mul_full;
    logic [31:0] add_op;
    logic [8:0]  ydays;
    logic [4:0]  mdays;
    logic [7:0]  mday_year;

    ecc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    assign mul_full  = mul_a * mul_b;
    assign ydays     = ecc_pkg::year_days(year_reg);
    // The month walk uses the running year when decoding, the target year when encoding.
    assign mday_year = act_reg ? ytgt_reg : year_reg;
    assign mdays     = ecc_pkg::month_days(month_reg, mday_year);

    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        day_next     = day_reg;
        year_next    = year_reg;
        ytgt_next    = ytgt_reg;
        month_next   = month_reg;
        cmon_next    = cmon_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        dom_next     = dom_reg;
        wday_next    = wday_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        div_start    = 1'b0;
        div_dividend = in_seconds;
        div_divisor  = ecc_pkg::SecsPerDay;
        mul_a        = '0;
        mul_b        = '0;
        add_op       = prod_reg;

        unique case (state_reg)
            ecc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    act_next  = action;
                    sec_next  = in_second;
                    min_next  = in_minute;
                    hour_next = in_hour;
                    dom_next  = in_day;
                    year_next = ecc_pkg::FirstYear;
                    day_next  = '0;
                    ytgt_next = (in_year < 7'd70) ? 8'({1'b0, in_year} + 8'd100)
                                                  : {1'b0, in_year};
                    // Month zero counts as January, months past twelve as December.
                    if (in_month == 4'd0)
                    begin
                        cmon_next = 4'd1;
                    end
                    else if (in_month > 4'd12)
                    begin
                        cmon_next = 4'd12;
                    end
                    else
                    begin
                        cmon_next = in_month;
                    end
                    if (action == ecc_pkg::ActToCal)
                    begin
                        div_start  = 1'b1;
                        state_next = ecc_pkg::ST_DIV_DAY;
                    end
                    else
                    begin
                        state_next = ecc_pkg::ST_C_YEAR;
                    end
                end
            end
            ecc_pkg::ST_DIV_DAY:
            begin
                if (div_done)
                begin
                    day_next     = div_quo[15:0];
                    div_start    = 1'b1;
                    div_dividend = 32'(div_rem);
                    div_divisor  = ecc_pkg::SecsPerHour;
                    state_next   = ecc_pkg::ST_DIV_HOUR;
                end
            end
            ecc_pkg::ST_DIV_HOUR:
            begin
                if (div_done)
                begin
                    hour_next    = div_quo[4:0];
                    div_start    = 1'b1;
                    div_dividend = 32'(div_rem);
                    div_divisor  = ecc_pkg::SecsPerMin;
                    state_next   = ecc_pkg::ST_DIV_MIN;
                end
            end
            ecc_pkg::ST_DIV_MIN:
            begin
                if (div_done)
                begin
                    min_next     = div_quo[5:0];
                    sec_next     = div_rem[5:0];
                    div_start    = 1'b1;
                    // The epoch day was a Thursday.
                    div_dividend = 32'(day_reg) + 32'd4;
                    div_divisor  = ecc_pkg::DaysPerWeek;
                    state_next   = ecc_pkg::ST_DIV_WDAY;
                end
            end
            ecc_pkg::ST_DIV_WDAY:
            begin
                if (div_done)
                begin
                    wday_next  = div_rem[2:0] + 3'd1;
                    state_next = ecc_pkg::ST_YEAR;
                end
            end
            ecc_pkg::ST_YEAR:
            begin
                if (day_reg >= 16'(ydays))
                begin
                    day_next  = day_reg - 16'(ydays);
                    year_next = year_reg + 8'd1;
                end
                else
                begin
                    month_next = '0;
                    state_next = ecc_pkg::ST_MONTH;
                end
            end
            ecc_pkg::ST_MONTH:
            begin
                if (month_reg < ecc_pkg::LastMonth0 && day_reg >= 16'(mdays))
                begin
                    day_next   = day_reg - 16'(mdays);
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    state_next = ecc_pkg::ST_DONE;
                end
            end
            ecc_pkg::ST_C_YEAR:
            begin
                if (year_reg < ytgt_reg)
                begin
                    day_next  = day_reg + 16'(ydays);
                    year_next = year_reg + 8'd1;
                end
                else
                begin
                    month_next = '0;
                    state_next = ecc_pkg::ST_C_MONTH;
                end
            end
            ecc_pkg::ST_C_MONTH:
            begin
                if ((month_reg + 4'd1) < cmon_reg)
                begin
                    day_next   = day_reg + 16'(mdays);
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    state_next = ecc_pkg::ST_MUL_DAY;
                end
            end
            ecc_pkg::ST_MUL_DAY:
            begin
                // Day of month zero steps one day back; all sums wrap at 32 bits.
                mul_a      = 32'(day_reg) + 32'(dom_reg) - 32'd1;
                mul_b      = ecc_pkg::SecsPerDay;
                prod_next  = mul_full[31:0];
                acc_next   = '0;
                state_next = ecc_pkg::ST_MUL_HOUR;
            end
            ecc_pkg::ST_MUL_HOUR:
            begin
                mul_a      = 32'(hour_reg);
                mul_b      = ecc_pkg::SecsPerHour;
                prod_next  = mul_full[31:0];
                acc_next   = acc_reg + add_op;
                state_next = ecc_pkg::ST_MUL_MIN;
            end
            ecc_pkg::ST_MUL_MIN:
            begin
                mul_a      = 32'(min_reg);
                mul_b      = ecc_pkg::SecsPerMin;
                prod_next  = mul_full[31:0];
                acc_next   = acc_reg + add_op;
                state_next = ecc_pkg::ST_ADD_SEC;
            end
            ecc_pkg::ST_ADD_SEC:
            begin
                add_op     = 32'(sec_reg) + prod_reg;
                acc_next   = acc_reg + add_op;
                state_next = ecc_pkg::ST_DONE;
            end
            ecc_pkg::ST_DONE:
            begin
                state_next = ecc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ecc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        day_reg   <= day_next;
        year_reg  <= year_next;
        ytgt_reg  <= ytgt_next;
        month_reg <= month_next;
        cmon_reg  <= cmon_next;
        sec_reg   <= sec_next;
        min_reg   <= min_next;
        hour_reg  <= hour_next;
        dom_reg   <= dom_next;
        wday_reg  <= wday_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
    end

    assign busy = (state_reg != ecc_pkg::ST_IDLE);
    assign done = (state_reg == ecc_pkg::ST_DONE);

    assign out_seconds = act_reg ? acc_reg : 32'd0;
    assign out_second  = act_reg ? 6'd0 : sec_reg;
    assign out_minute  = act_reg ? 6'd0 : min_reg;
    assign out_hour    = act_reg ? 5'd0 : hour_reg;
    assign out_day     = act_reg ? 5'd0 : 5'(day_reg[4:0] + 5'd1);
    assign out_month   = act_reg ? 4'd0 : 4'(month_reg + 4'd1);
    assign out_year    = act_reg ? 8'd0 : year_reg;
    assign out_weekday = act_reg ? 3'd0 : wday_reg;

endmodule

[rtl/ecc_div.sv]
// Constant divider by reciprocal multiplication, shared by all four division steps.
module ecc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ecc_pkg::DivBits-1:0] dividend,
    input  logic [ecc_pkg::DvsW-1:0]    divisor,
    output logic [ecc_pkg::DivBits-1:0] quotient,
    output logic [ecc_pkg::DvsW-1:0]    remainder,
    output logic                      done
);

    logic                          qph_reg, qph_next;
    logic                          rph_reg, rph_next;
    logic                          done_reg, done_next;
    logic [ecc_pkg::DivBits-1:0]   num_reg, num_next;
    logic [ecc_pkg::DvsW-1:0]      dvs_reg, dvs_next;
    logic [ecc_pkg::DivBits-1:0]   quo_reg, quo_next;
    logic [ecc_pkg::DvsW-1:0]      rem_reg, rem_next;
    logic [ecc_pkg::MagicW-1:0]    magic;
    logic [ecc_pkg::PreW-1:0]      pre_sh;
    logic [ecc_pkg::PostW-1:0]     post_sh;
    logic [ecc_pkg::DivBits-1:0]   mul_a;
    logic [ecc_pkg::MagicW-1:0]    mul_b;
    logic [ecc_pkg::ProdW-1:0]     prod;
    logic [ecc_pkg::ProdW-1:0]     prod_sh;
    logic [ecc_pkg::DivBits-1:0]   diff;

    // The shifted product is the exact quotient for every dividend the sequencer can pass.
    always_comb
    begin
        unique case (dvs_reg)
            ecc_pkg::SecsPerDay:
            begin
                magic   = ecc_pkg::MagicDay;
                pre_sh  = ecc_pkg::PreDay;
                post_sh = ecc_pkg::PostDay;
            end
            ecc_pkg::SecsPerHour:
            begin
                magic   = ecc_pkg::MagicHour;
                pre_sh  = ecc_pkg::PreNone;
                post_sh = ecc_pkg::PostHour;
            end
            ecc_pkg::SecsPerMin:
            begin
                magic   = ecc_pkg::MagicMin;
                pre_sh  = ecc_pkg::PreNone;
                post_sh = ecc_pkg::PostMin;
            end
            default:
            begin
                magic   = ecc_pkg::MagicWeek;
                pre_sh  = ecc_pkg::PreNone;
                post_sh = ecc_pkg::PostWeek;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign prod_sh = prod >> post_sh;
    assign diff    = num_reg - prod[ecc_pkg::DivBits-1:0];

    always_comb
    begin
        qph_next  = 1'b0;
        rph_next  = 1'b0;
        done_next = 1'b0;
        num_next  = num_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        mul_a     = quo_reg;
        mul_b     = ecc_pkg::MagicW'(dvs_reg);
        if (start)
        begin
            qph_next = 1'b1;
            num_next = dividend;
            dvs_next = divisor;
        end
        else if (qph_reg)
        begin
            mul_a    = num_reg >> pre_sh;
            mul_b    = magic;
            quo_next = prod_sh[ecc_pkg::DivBits-1:0];
            rph_next = 1'b1;
        end
        else if (rph_reg)
        begin
            // The same multiplier forms quotient times divisor for the remainder.
            rem_next  = diff[ecc_pkg::DvsW-1:0];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qph_reg  <= 1'b0;
            rph_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            qph_reg  <= qph_next;
            rph_reg  <= rph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

[rtl/ecc_checker.sv]
// Port-level checker for the epoch calendar converter, bound to the top level.
module ecc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] out_seconds,
    input logic [5:0]  out_second,
    input logic [5:0]  out_minute,
    input logic [4:0]  out_hour,
    input logic [4:0]  out_day,
    input logic [3:0]  out_month,
    input logic [7:0]  out_year,
    input logic [2:0]  out_weekday
);

    // A request taken while idle must make the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // A result only appears while a request is in flight.
    a_done_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    // Exactly one result per request: the block is idle right after the strobe.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("block not idle after result");

    // Fields of the unused direction are zero.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (out_seconds == 32'd0 ||
                  (out_second == 6'd0 && out_minute == 6'd0 && out_hour == 5'd0 &&
                   out_day == 5'd0 && out_month == 4'd0 && out_year == 8'd0 &&
                   out_weekday == 3'd0)))
        else $error("both directions drive result fields");

    // A calendar result always carries a valid weekday, day and month.
    a_calendar_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_year != 8'd0) |-> (out_weekday != 3'd0 && out_day != 5'd0 &&
                                        out_month != 4'd0 && out_month <= 4'd12))
        else $error("calendar result out of range");

endmodule

bind epoch_calendar_converter_top ecc_checker u_ecc_checker (.*);
